@@ hdl/emru_pkg.sv @@
// Shared types and constants for the extent map range update unit.
// No dependencies.
package emru_pkg;

  localparam int MAX_EXTENTS = 256;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int OFF_W = 64;
  localparam int ST_W = 3;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_BAD_RANGE = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  // how the assigned range lands on the first extent it reaches
  typedef enum logic [1:0] {
    K_NEW,   // no overlapping extent: insert
    K_HEAD,  // range covers the head of another-state extent
    K_TAIL,  // range covers the tail of another-state extent
    K_MID    // range strictly inside another-state extent
  } upd_kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDW,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_W_TRIM,
    S_OPEN_RD,
    S_OPEN_WR,
    S_OPEN_END,
    S_W_ONE,
    S_W_TWO,
    S_MRG_RD,
    S_MRG_CHK,
    S_MRG_END,
    S_CLOSE_RD,
    S_CLOSE_WR,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] size;
    logic [ST_W-1:0]  st;
  } extent_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    extent_t          data;
  } ram_wr_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    extent_t          ext;
  } result_t;

endpackage

@@ hdl/extent_map_range_update_unit.sv @@
// Extent map range update unit: top level with table RAM, sequencer and
// output register. Depends on emru_pkg, emru_ram, emru_seq.
//
// Input channel (in_valid/in_stall) takes one word per item: either an
// assign of range_state to [range_start, range_end) or a read of the extent
// at entry_index. Every item yields exactly one output word (out_valid /
// out_stall) with status, the extent count after the item, and for a read
// the stored extent.
// Items are handled one at a time. A read of a valid index passes through
// S_RDW and S_RESP to the output register. An update scans the table
// (S_SCAN_RD, S_SCAN_CHK per extent) until it reaches the range, then opens
// a gap (S_OPEN_RD, S_OPEN_WR per shifted extent), merges forward (S_MRG_RD,
// S_MRG_CHK per extent visited) and closes the gap (S_CLOSE_RD, S_CLOSE_WR
// per shifted extent). All steps use the single table RAM.
// Update needing more entries than are free: it is dropped, status reports full.
// Reset empties the table at once (count cleared); no clearing pass.
// A result waiting under out_stall does not block the next item from being
// accepted and worked on; only its own result waits for the register.
module extent_map_range_update_unit
  import emru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             opcode,
  input  logic [63:0]      range_start,
  input  logic [63:0]      range_end,
  input  logic [2:0]       range_state,
  input  logic [7:0]       entry_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [8:0]       entry_count,
  output logic [63:0]      entry_offset,
  output logic [63:0]      entry_size,
  output logic [2:0]       entry_state
);

  ram_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  extent_t          rd_data;
  logic             res_free, res_load;
  result_t          res;

  emru_ram #(
    .DEPTH (MAX_EXTENTS),
    .WIDTH ($bits(extent_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  emru_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .range_start (range_start),
    .range_end   (range_end),
    .range_state (range_state),
    .entry_index (entry_index),
    .res_free    (res_free),
    .res_load    (res_load),
    .res         (res),
    .wr          (wr),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status       <= res.status;
      entry_count  <= res.count;
      entry_offset <= res.ext.off;
      entry_size   <= res.ext.size;
      entry_state  <= res.ext.st;
    end
  end

endmodule

@@ hdl/emru_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module emru_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 131
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/emru_seq.sv @@
// Sequencer for the extent table: scan, gap open/close, merge and readout.
// Depends on emru_pkg; drives the port of emru_ram.
module emru_seq
  import emru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             opcode,
  input  logic [OFF_W-1:0] range_start,
  input  logic [OFF_W-1:0] range_end,
  input  logic [ST_W-1:0]  range_state,
  input  logic [IDX_W-1:0] entry_index,
  input  logic             res_free,
  output logic             res_load,
  output result_t          res,
  output ram_wr_t          wr,
  output logic [IDX_W-1:0] rd_addr,
  input  extent_t          rd_data
);

  seq_state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ix;
  logic [CNT_W-1:0] at;
  logic [CNT_W-1:0] shrink;
  logic [1:0]       gap_k;
  logic [IDX_W-1:0] cur;
  upd_kind_t        kind;
  logic [OFF_W-1:0] s, e, es, ee, off, cend;
  logic [ST_W-1:0]  st, old;
  logic             found;
  status_t          res_status;
  extent_t          res_ext;

  logic [OFF_W-1:0] rd_end;
  logic             accept;
  logic             full1, full2;
  logic [CNT_W-1:0] cur_nx;

  assign rd_end = rd_data.off + rd_data.size;
  assign accept = in_valid && !in_stall;
  assign full1  = ({1'b0, count} + 10'd1) > 10'(MAX_EXTENTS);
  assign full2  = ({1'b0, count} + 10'd2) > 10'(MAX_EXTENTS);
  assign cur_nx = {1'b0, cur} + 9'd1;
  assign in_stall = (state != S_IDLE);
  assign res_load = (state == S_RESP) && res_free;
  assign res = '{status: res_status, count: count, ext: res_ext};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    wr         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_READ) begin
            if ({1'b0, entry_index} >= count) begin
              state_next = S_RESP;
            end else begin
              rd_addr    = entry_index;
              state_next = S_RDW;
            end
          end else if (range_end <= range_start) begin
            state_next = S_RESP;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_RDW: state_next = S_RESP;
      S_SCAN_RD: begin
        if (ptr == count) begin
          state_next = S_DECIDE;
        end else begin
          rd_addr    = ptr[IDX_W-1:0];
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: state_next = (rd_end < s) ? S_SCAN_RD : S_DECIDE;
      S_DECIDE: begin
        if (!found) begin
          state_next = full1 ? S_RESP : S_OPEN_RD;
        end else if (old == st || (s <= es && e >= ee)) begin
          state_next = S_MRG_RD;
        end else if (s <= es) begin
          state_next = full1 ? S_RESP : S_OPEN_RD;
        end else if (e >= ee) begin
          state_next = full1 ? S_RESP : S_W_TRIM;
        end else begin
          state_next = full2 ? S_RESP : S_W_TRIM;
        end
      end
      S_W_TRIM: begin
        wr = '{en: 1'b1, addr: ix[IDX_W-1:0], data: '{off: es, size: s - es, st: old}};
        state_next = S_OPEN_RD;
      end
      S_OPEN_RD: begin
        if (ptr == at) begin
          state_next = S_OPEN_END;
        end else begin
          rd_addr    = IDX_W'(ptr - 9'd1);
          state_next = S_OPEN_WR;
        end
      end
      S_OPEN_WR: begin
        wr = '{en: 1'b1, addr: IDX_W'(ptr - 9'd1 + {7'd0, gap_k}), data: rd_data};
        state_next = S_OPEN_RD;
      end
      S_OPEN_END: begin
        state_next = (kind == K_NEW || kind == K_TAIL) ? S_MRG_RD : S_W_ONE;
      end
      S_W_ONE: begin
        if (kind == K_HEAD) begin
          wr = '{en: 1'b1, addr: IDX_W'(ix + 9'd1), data: '{off: e, size: ee - e, st: old}};
        end else begin
          wr = '{en: 1'b1, addr: IDX_W'(ix + 9'd1), data: '{off: s, size: e - s, st: st}};
        end
        state_next = S_W_TWO;
      end
      S_W_TWO: begin
        if (kind == K_HEAD) begin
          wr = '{en: 1'b1, addr: ix[IDX_W-1:0], data: '{off: s, size: e - s, st: st}};
        end else begin
          wr = '{en: 1'b1, addr: IDX_W'(ix + 9'd2), data: '{off: e, size: ee - e, st: old}};
        end
        state_next = S_RESP;
      end
      S_MRG_RD: begin
        if (ptr == count) begin
          state_next = S_MRG_END;
        end else begin
          rd_addr    = ptr[IDX_W-1:0];
          state_next = S_MRG_CHK;
        end
      end
      S_MRG_CHK: begin
        if (rd_data.off > cend) begin
          state_next = S_MRG_END;
        end else if (rd_end > cend && rd_data.st != st) begin
          // other state reaches past us: it keeps its tail, stop
          wr = '{en: 1'b1, addr: ptr[IDX_W-1:0],
                 data: '{off: cend, size: rd_end - cend, st: rd_data.st}};
          state_next = S_MRG_END;
        end else begin
          state_next = S_MRG_RD;
        end
      end
      S_MRG_END: begin
        wr = '{en: 1'b1, addr: cur, data: '{off: off, size: cend - off, st: st}};
        state_next = (ptr > cur_nx) ? S_CLOSE_RD : S_RESP;
      end
      S_CLOSE_RD: begin
        if (ptr == count) begin
          state_next = S_RESP;
        end else begin
          rd_addr    = ptr[IDX_W-1:0];
          state_next = S_CLOSE_WR;
        end
      end
      S_CLOSE_WR: begin
        wr = '{en: 1'b1, addr: IDX_W'(ptr - shrink), data: rd_data};
        state_next = S_CLOSE_RD;
      end
      S_RESP: if (res_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // count is control state; the rest is datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_OPEN_END) begin
      count <= count + {7'd0, gap_k};
    end else if (state == S_CLOSE_RD && ptr == count) begin
      count <= count - shrink;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          s       <= range_start;
          e       <= range_end;
          st      <= range_state;
          ptr     <= '0;
          found   <= 1'b0;
          res_ext <= '0;
          if (opcode == OP_READ) begin
            res_status <= ({1'b0, entry_index} >= count) ? STAT_BAD_INDEX : STAT_OK;
          end else begin
            res_status <= (range_end < range_start) ? STAT_BAD_RANGE : STAT_OK;
          end
        end
      end
      S_RDW: res_ext <= rd_data;
      S_SCAN_RD: begin
        if (ptr == count) ix <= ptr;
      end
      S_SCAN_CHK: begin
        es  <= rd_data.off;
        ee  <= rd_end;
        old <= rd_data.st;
        ix  <= ptr;
        if (rd_end < s) begin
          ptr <= ptr + 9'd1;
        end else begin
          found <= (rd_data.off <= e);
        end
      end
      S_DECIDE: begin
        gap_k <= 2'd1;
        ptr   <= count;
        cur   <= ix[IDX_W-1:0];
        off   <= s;
        cend  <= e;
        at    <= ix;
        if (!found) begin
          kind <= K_NEW;
          if (full1) res_status <= STAT_FULL;
        end else if (old == st) begin
          off  <= (s < es) ? s : es;
          cend <= (e > ee) ? e : ee;
          ptr  <= ix + 9'd1;
        end else if (s <= es && e >= ee) begin
          ptr <= ix + 9'd1;
        end else if (s <= es) begin
          kind <= K_HEAD;
          if (full1) res_status <= STAT_FULL;
        end else if (e >= ee) begin
          kind <= K_TAIL;
          at   <= ix + 9'd1;
          cur  <= IDX_W'(ix + 9'd1);
          if (full1) res_status <= STAT_FULL;
        end else begin
          kind  <= K_MID;
          at    <= ix + 9'd1;
          gap_k <= 2'd2;
          if (full2) res_status <= STAT_FULL;
        end
      end
      S_OPEN_WR: ptr <= ptr - 9'd1;
      S_OPEN_END: ptr <= cur_nx;
      S_MRG_CHK: begin
        if (rd_data.off <= cend) begin
          if (rd_end <= cend) begin
            ptr <= ptr + 9'd1;
          end else if (rd_data.st == st) begin
            cend <= rd_end;
            ptr  <= ptr + 9'd1;
          end
        end
      end
      S_MRG_END: shrink <= ptr - cur_nx;
      S_CLOSE_WR: ptr <= ptr + 9'd1;
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_EXTENTS))
    else $error("extent count beyond table size");

  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state != S_IDLE && state != S_RESP))
    else $error("table write outside an update");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word did not start work");

  a_count_steady: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESP) |=> $stable(count))
    else $error("count changed while not updating");

endmodule
